// ----- hdl/mtp_pkg.sv -----
// ----------------------------------------------------------------------------
// mtp_pkg
// Shared types, command codes and register indexes of the match timer.
// ----------------------------------------------------------------------------
package mtp_pkg;

  // Default width of the timer count
  localparam int MTP_COUNT_BITS = 32;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;
  localparam int ACT_W  = 3;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  // Register word indexes
  localparam logic [IDX_W-1:0] REG_FLAG        = 3'd0;
  localparam logic [IDX_W-1:0] REG_CONTROL     = 3'd1;
  localparam logic [IDX_W-1:0] REG_COUNT       = 3'd2;
  localparam logic [IDX_W-1:0] REG_PRESCALE    = 3'd3;
  localparam logic [IDX_W-1:0] REG_MATCH_CTRL  = 3'd5;
  localparam logic [IDX_W-1:0] REG_MATCH_VALUE = 3'd6;

  // Unmapped word indexes: read zero, ignore writes
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Bit positions in the control, match control and flag registers
  localparam int CTRL_ENABLE_BIT = 0;
  localparam int CTRL_RESET_BIT  = 1;
  localparam int ACT_IRQ_BIT     = 0;
  localparam int ACT_RESET_BIT   = 1;
  localparam int ACT_STOP_BIT    = 2;
  localparam int FLAG_CLEAR_BIT  = 0;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
  } mtp_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_pending;
  } mtp_result_t;

endpackage

// ----- hdl/mtp_if.sv -----
// ----------------------------------------------------------------------------
// mtp_if
// Valid/ready channels carrying timer items and timer results.
// ----------------------------------------------------------------------------
interface mtp_item_if import mtp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [IDX_W-1:0]  reg_index;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output cmd, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input cmd, input reg_index, input write_data,
                output ready);
endinterface

interface mtp_result_if import mtp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq_pending;

  modport source (output valid, output read_data, output irq_pending,
                  input ready);
  modport sink (input valid, input read_data, input irq_pending,
                output ready);
endinterface

// ----- hdl/mtp_core.sv -----
// ----------------------------------------------------------------------------
// mtp_core
// Timer state: flag, control, prescaler, count and match registers, updated
// by one tick, read or write per accepted transfer.
// ----------------------------------------------------------------------------
module mtp_core import mtp_pkg::*; #(
  parameter int COUNT_BITS = MTP_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  mtp_item_t   item,
  output mtp_result_t result
);

  localparam int CMP_W = (COUNT_BITS > DATA_W) ? COUNT_BITS : DATA_W;

  logic                  match_flag, match_flag_next;
  logic                  count_enable, count_enable_next;
  logic                  count_reset, count_reset_next;
  logic [COUNT_BITS-1:0] timer_count, timer_count_next;
  logic [DATA_W-1:0]     prescale_limit, prescale_limit_next;
  logic [DATA_W-1:0]     prescale_count, prescale_count_next;
  logic [ACT_W-1:0]      match_actions, match_actions_next;
  logic [DATA_W-1:0]     match_value, match_value_next;

  logic [COUNT_BITS-1:0] count_inc;
  logic                  count_hit;
  logic [DATA_W-1:0]     read_data;

  // Advanced count and its compare with the match value
  assign count_inc = timer_count + COUNT_BITS'(1);
  assign count_hit = (CMP_W'(count_inc) == CMP_W'(match_value));

  // Work out the state after this item and the read value
  always_comb begin
    match_flag_next     = match_flag;
    count_enable_next   = count_enable;
    count_reset_next    = count_reset;
    timer_count_next    = timer_count;
    prescale_limit_next = prescale_limit;
    prescale_count_next = prescale_count;
    match_actions_next  = match_actions;
    match_value_next    = match_value;
    read_data           = '0;
    case (item.cmd)
      CMD_TICK: begin
        if (count_reset) begin
          timer_count_next    = '0;
          prescale_count_next = '0;
        end else if (count_enable) begin
          if (prescale_count < prescale_limit) begin
            prescale_count_next = prescale_count + DATA_W'(1);
          end else begin
            prescale_count_next = '0;
            timer_count_next    = count_inc;
            if (count_hit) begin
              if (match_actions[ACT_IRQ_BIT]) match_flag_next = 1'b1;
              if (match_actions[ACT_RESET_BIT]) timer_count_next = '0;
              if (match_actions[ACT_STOP_BIT]) count_enable_next = 1'b0;
            end
          end
        end
      end
      CMD_READ: begin
        case (item.reg_index)
          REG_FLAG:        read_data = DATA_W'(match_flag);
          REG_CONTROL:     read_data = DATA_W'({count_reset, count_enable});
          REG_COUNT:       read_data = DATA_W'(timer_count);
          REG_PRESCALE:    read_data = prescale_limit;
          REG_MATCH_CTRL:  read_data = DATA_W'(match_actions);
          REG_MATCH_VALUE: read_data = match_value;
          default:         read_data = '0;
        endcase
      end
      CMD_WRITE: begin
        case (item.reg_index)
          REG_FLAG: begin
            if (item.write_data[FLAG_CLEAR_BIT]) match_flag_next = 1'b0;
          end
          REG_CONTROL: begin
            count_enable_next = item.write_data[CTRL_ENABLE_BIT];
            count_reset_next  = item.write_data[CTRL_RESET_BIT];
            if (item.write_data[CTRL_RESET_BIT]) begin
              timer_count_next    = '0;
              prescale_count_next = '0;
            end
          end
          REG_PRESCALE:    prescale_limit_next = item.write_data;
          REG_MATCH_CTRL:  match_actions_next  = item.write_data[ACT_W-1:0];
          REG_MATCH_VALUE: match_value_next    = item.write_data;
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Update state on each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      match_flag     <= 1'b0;
      count_enable   <= 1'b0;
      count_reset    <= 1'b0;
      timer_count    <= '0;
      prescale_limit <= '0;
      prescale_count <= '0;
      match_actions  <= '0;
      match_value    <= '0;
    end else if (accept) begin
      match_flag     <= match_flag_next;
      count_enable   <= count_enable_next;
      count_reset    <= count_reset_next;
      timer_count    <= timer_count_next;
      prescale_limit <= prescale_limit_next;
      prescale_count <= prescale_count_next;
      match_actions  <= match_actions_next;
      match_value    <= match_value_next;
    end
  end

  assign result.read_data   = read_data;
  assign result.irq_pending = match_flag_next;

  // Counters stay cleared while held in reset
  a_hold_clear: assert property (@(posedge clk) disable iff (rst)
    count_reset |-> (timer_count == '0) && (prescale_count == '0))
    else $error("counters not cleared while held in reset");

  // The flag is only raised by a tick
  a_flag_by_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(match_flag) |-> $past(accept) && ($past(item.cmd) == CMD_TICK))
    else $error("match flag raised without a tick");

  // Counting stops only through a tick or a control write
  a_stop_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(count_enable) |-> $past(accept) &&
      (($past(item.cmd) == CMD_TICK) || ($past(item.cmd) == CMD_WRITE)))
    else $error("counting stopped without cause");

endmodule

// ----- hdl/match_timer_with_prescaler_top.sv -----
// ----------------------------------------------------------------------------
// match_timer_with_prescaler_top
// Prescaled timer with one match register behind a word register map.
// ----------------------------------------------------------------------------
// Each transfer on req is a timer tick, a register read or a register write,
// and each yields exactly one transfer on rsp from the result register, carrying the
// read value (zero for ticks and writes) and the interrupt flag after the
// item. The block takes one item per cycle: the state update is a single
// pass of logic from the accepted item into the state and the result
// register, and req stays ready as long as the result register is empty or
// being emptied in the same cycle.
module match_timer_with_prescaler_top import mtp_pkg::*; #(
  parameter int COUNT_BITS = MTP_COUNT_BITS
) (
  input logic             clk,
  input logic             rst,
  mtp_item_if.sink        req,
  mtp_result_if.source    rsp
);

  logic        accept;
  mtp_item_t   item;
  mtp_result_t result;
  mtp_result_t out_data;
  logic        out_valid;

  // Take a new item whenever the result register is free or draining
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign item.cmd        = req.cmd;
  assign item.reg_index  = req.reg_index;
  assign item.write_data = req.write_data;

  mtp_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_data   = out_data.read_data;
  assign rsp.irq_pending = out_data.irq_pending;

  // Every accepted item yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("accepted item produced no result");

  // Undefined offsets read zero
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    accept && (req.cmd == CMD_READ) &&
      ((req.reg_index == REG_SPARE_LO) || (req.reg_index == REG_SPARE_HI))
      |=> (rsp.read_data == '0))
    else $error("undefined offset read non-zero");

  // A clearing write to the flag register leaves the interrupt low
  a_flag_clear: assert property (@(posedge clk) disable iff (rst)
    accept && (req.cmd == CMD_WRITE) && (req.reg_index == REG_FLAG) &&
      req.write_data[FLAG_CLEAR_BIT] |=> !rsp.irq_pending)
    else $error("flag not cleared by write");

endmodule
